### rtl/core/iwd_pkg.sv
// ----------------------------------------------------------------------------
// iwd_pkg
// Shared types, opcode and function codes, mnemonic codes and reserved-field
// masks for the MIPS32 instruction word decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package iwd_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CODE_W  = 6;
    localparam int unsigned REG_W   = 5;
    localparam int unsigned IMM_W   = 16;
    localparam int unsigned TGT_W   = 26;
    localparam int unsigned FIELD_W = 6;

    // Result packing, first field in the low bits, padded to whole bytes.
    localparam int unsigned RES_BITS = CODE_W + 4 * REG_W + IMM_W + TGT_W;
    localparam int unsigned RES_W    = ((RES_BITS + 7) / 8) * 8;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [CODE_W-1:0]  t_code;
    typedef logic [FIELD_W-1:0] t_field;

    // Opcodes (bits 31..26)
    localparam t_field OP_SPECIAL = 6'h00;
    localparam t_field OP_J       = 6'h02;
    localparam t_field OP_JAL     = 6'h03;
    localparam t_field OP_BEQ     = 6'h04;
    localparam t_field OP_BNE     = 6'h05;
    localparam t_field OP_ADDI    = 6'h08;
    localparam t_field OP_ADDIU   = 6'h09;
    localparam t_field OP_SLTI    = 6'h0a;
    localparam t_field OP_SLTIU   = 6'h0b;
    localparam t_field OP_ANDI    = 6'h0c;
    localparam t_field OP_ORI     = 6'h0d;
    localparam t_field OP_XORI    = 6'h0e;
    localparam t_field OP_LUI     = 6'h0f;
    localparam t_field OP_LB      = 6'h20;
    localparam t_field OP_LH      = 6'h21;
    localparam t_field OP_LW      = 6'h23;
    localparam t_field OP_LBU     = 6'h24;
    localparam t_field OP_LHU     = 6'h25;
    localparam t_field OP_SB      = 6'h28;
    localparam t_field OP_SH      = 6'h29;
    localparam t_field OP_SW      = 6'h2b;

    // Function codes (bits 5..0) under OP_SPECIAL
    localparam t_field FN_SLL     = 6'h00;
    localparam t_field FN_SRL     = 6'h02;
    localparam t_field FN_SRA     = 6'h03;
    localparam t_field FN_SLLV    = 6'h04;
    localparam t_field FN_SRLV    = 6'h06;
    localparam t_field FN_SRAV    = 6'h07;
    localparam t_field FN_JR      = 6'h08;
    localparam t_field FN_JALR    = 6'h09;
    localparam t_field FN_SYSCALL = 6'h0c;
    localparam t_field FN_MFHI    = 6'h10;
    localparam t_field FN_MTHI    = 6'h11;
    localparam t_field FN_MFLO    = 6'h12;
    localparam t_field FN_MTLO    = 6'h13;
    localparam t_field FN_MULT    = 6'h18;
    localparam t_field FN_MULTU   = 6'h19;
    localparam t_field FN_DIV     = 6'h1a;
    localparam t_field FN_DIVU    = 6'h1b;
    localparam t_field FN_ADD     = 6'h20;
    localparam t_field FN_ADDU    = 6'h21;
    localparam t_field FN_SUB     = 6'h22;
    localparam t_field FN_SUBU    = 6'h23;
    localparam t_field FN_AND     = 6'h24;
    localparam t_field FN_OR      = 6'h25;
    localparam t_field FN_XOR     = 6'h26;
    localparam t_field FN_NOR     = 6'h27;
    localparam t_field FN_SLT     = 6'h2a;
    localparam t_field FN_SLTU    = 6'h2b;

    // Mnemonic codes
    localparam t_code MN_UNKNOWN = 6'd0;
    localparam t_code MN_ADD     = 6'd1;
    localparam t_code MN_ADDU    = 6'd2;
    localparam t_code MN_AND     = 6'd3;
    localparam t_code MN_DIV     = 6'd4;
    localparam t_code MN_DIVU    = 6'd5;
    localparam t_code MN_JALR    = 6'd6;
    localparam t_code MN_JR      = 6'd7;
    localparam t_code MN_MFHI    = 6'd8;
    localparam t_code MN_MFLO    = 6'd9;
    localparam t_code MN_MTHI    = 6'd10;
    localparam t_code MN_MTLO    = 6'd11;
    localparam t_code MN_MULT    = 6'd12;
    localparam t_code MN_MULTU   = 6'd13;
    localparam t_code MN_NOR     = 6'd14;
    localparam t_code MN_OR      = 6'd15;
    localparam t_code MN_SLL     = 6'd16;
    localparam t_code MN_SLLV    = 6'd17;
    localparam t_code MN_SLT     = 6'd18;
    localparam t_code MN_SLTU    = 6'd19;
    localparam t_code MN_SRA     = 6'd20;
    localparam t_code MN_SRAV    = 6'd21;
    localparam t_code MN_SRL     = 6'd22;
    localparam t_code MN_SRLV    = 6'd23;
    localparam t_code MN_SUB     = 6'd24;
    localparam t_code MN_SUBU    = 6'd25;
    localparam t_code MN_SYSCALL = 6'd26;
    localparam t_code MN_XOR     = 6'd27;
    localparam t_code MN_J       = 6'd28;
    localparam t_code MN_JAL     = 6'd29;
    localparam t_code MN_ADDI    = 6'd30;
    localparam t_code MN_ADDIU   = 6'd31;
    localparam t_code MN_ANDI    = 6'd32;
    localparam t_code MN_ORI     = 6'd33;
    localparam t_code MN_XORI    = 6'd34;
    localparam t_code MN_LUI     = 6'd35;
    localparam t_code MN_SLTI    = 6'd36;
    localparam t_code MN_SLTIU   = 6'd37;
    localparam t_code MN_BEQ     = 6'd38;
    localparam t_code MN_BNE     = 6'd39;
    localparam t_code MN_LB      = 6'd40;
    localparam t_code MN_LBU     = 6'd41;
    localparam t_code MN_LH      = 6'd42;
    localparam t_code MN_LHU     = 6'd43;
    localparam t_code MN_LW      = 6'd44;
    localparam t_code MN_SB      = 6'd45;
    localparam t_code MN_SH      = 6'd46;
    localparam t_code MN_SW      = 6'd47;

    // Reserved fields that must be zero
    localparam t_word MSK_NONE    = 32'h0000_0000;
    localparam t_word MSK_SHAMT   = 32'h0000_07C0;
    localparam t_word MSK_RD_SH   = 32'h0000_FFC0;
    localparam t_word MSK_RT_SH   = 32'h001F_07C0;
    localparam t_word MSK_RTRDSH  = 32'h001F_FFC0;
    localparam t_word MSK_RSRT_SH = 32'h03FF_07C0;
    localparam t_word MSK_ALLLOW  = 32'h03FF_FFC0;
    localparam t_word MSK_RS      = 32'h03E0_0000;

endpackage : iwd_pkg

`default_nettype wire

### rtl/core/iwd_classify.sv
// ----------------------------------------------------------------------------
// iwd_classify
// Combinational mnemonic lookup with per-mnemonic reserved-field check.
// ----------------------------------------------------------------------------
`default_nettype none

module iwd_classify
    import iwd_pkg::*;
(
    input  wire t_word i_word,
    output t_code      o_code
);

    t_field op;
    t_field fn;
    t_code  code_raw;
    t_word  zero_mask;

    assign op = i_word[31:26];
    assign fn = i_word[5:0];

    always_comb begin
        code_raw  = MN_UNKNOWN;
        zero_mask = MSK_NONE;
        if (op == OP_SPECIAL) begin
            unique case (fn)
                FN_ADD:     begin code_raw = MN_ADD;     zero_mask = MSK_SHAMT;   end
                FN_ADDU:    begin code_raw = MN_ADDU;    zero_mask = MSK_SHAMT;   end
                FN_AND:     begin code_raw = MN_AND;     zero_mask = MSK_SHAMT;   end
                FN_DIV:     begin code_raw = MN_DIV;     zero_mask = MSK_RD_SH;   end
                FN_DIVU:    begin code_raw = MN_DIVU;    zero_mask = MSK_RD_SH;   end
                FN_JALR:    begin code_raw = MN_JALR;    zero_mask = MSK_RT_SH;   end
                FN_JR:      begin code_raw = MN_JR;      zero_mask = MSK_RTRDSH;  end
                FN_MFHI:    begin code_raw = MN_MFHI;    zero_mask = MSK_RSRT_SH; end
                FN_MFLO:    begin code_raw = MN_MFLO;    zero_mask = MSK_RSRT_SH; end
                FN_MTHI:    begin code_raw = MN_MTHI;    zero_mask = MSK_RTRDSH;  end
                FN_MTLO:    begin code_raw = MN_MTLO;    zero_mask = MSK_RTRDSH;  end
                FN_MULT:    begin code_raw = MN_MULT;    zero_mask = MSK_RD_SH;   end
                FN_MULTU:   begin code_raw = MN_MULTU;   zero_mask = MSK_RD_SH;   end
                FN_NOR:     begin code_raw = MN_NOR;     zero_mask = MSK_SHAMT;   end
                FN_OR:      begin code_raw = MN_OR;      zero_mask = MSK_SHAMT;   end
                FN_SLL:     begin code_raw = MN_SLL;     zero_mask = MSK_NONE;    end
                FN_SLLV:    begin code_raw = MN_SLLV;    zero_mask = MSK_SHAMT;   end
                FN_SLT:     begin code_raw = MN_SLT;     zero_mask = MSK_SHAMT;   end
                FN_SLTU:    begin code_raw = MN_SLTU;    zero_mask = MSK_SHAMT;   end
                FN_SRA:     begin code_raw = MN_SRA;     zero_mask = MSK_NONE;    end
                FN_SRAV:    begin code_raw = MN_SRAV;    zero_mask = MSK_SHAMT;   end
                FN_SRL:     begin code_raw = MN_SRL;     zero_mask = MSK_NONE;    end
                FN_SRLV:    begin code_raw = MN_SRLV;    zero_mask = MSK_SHAMT;   end
                FN_SUB:     begin code_raw = MN_SUB;     zero_mask = MSK_SHAMT;   end
                FN_SUBU:    begin code_raw = MN_SUBU;    zero_mask = MSK_SHAMT;   end
                FN_SYSCALL: begin code_raw = MN_SYSCALL; zero_mask = MSK_ALLLOW;  end
                FN_XOR:     begin code_raw = MN_XOR;     zero_mask = MSK_SHAMT;   end
                default:    begin code_raw = MN_UNKNOWN; zero_mask = MSK_NONE;    end
            endcase
        end else begin
            unique case (op)
                OP_J:     begin code_raw = MN_J;       zero_mask = MSK_NONE; end
                OP_JAL:   begin code_raw = MN_JAL;     zero_mask = MSK_NONE; end
                OP_ADDI:  begin code_raw = MN_ADDI;    zero_mask = MSK_NONE; end
                OP_ADDIU: begin code_raw = MN_ADDIU;   zero_mask = MSK_NONE; end
                OP_ANDI:  begin code_raw = MN_ANDI;    zero_mask = MSK_NONE; end
                OP_ORI:   begin code_raw = MN_ORI;     zero_mask = MSK_NONE; end
                OP_XORI:  begin code_raw = MN_XORI;    zero_mask = MSK_NONE; end
                OP_LUI:   begin code_raw = MN_LUI;     zero_mask = MSK_RS;   end
                OP_SLTI:  begin code_raw = MN_SLTI;    zero_mask = MSK_NONE; end
                OP_SLTIU: begin code_raw = MN_SLTIU;   zero_mask = MSK_NONE; end
                OP_BEQ:   begin code_raw = MN_BEQ;     zero_mask = MSK_NONE; end
                OP_BNE:   begin code_raw = MN_BNE;     zero_mask = MSK_NONE; end
                OP_LB:    begin code_raw = MN_LB;      zero_mask = MSK_NONE; end
                OP_LBU:   begin code_raw = MN_LBU;     zero_mask = MSK_NONE; end
                OP_LH:    begin code_raw = MN_LH;      zero_mask = MSK_NONE; end
                OP_LHU:   begin code_raw = MN_LHU;     zero_mask = MSK_NONE; end
                OP_LW:    begin code_raw = MN_LW;      zero_mask = MSK_NONE; end
                OP_SB:    begin code_raw = MN_SB;      zero_mask = MSK_NONE; end
                OP_SH:    begin code_raw = MN_SH;      zero_mask = MSK_NONE; end
                OP_SW:    begin code_raw = MN_SW;      zero_mask = MSK_NONE; end
                default:  begin code_raw = MN_UNKNOWN; zero_mask = MSK_NONE; end
            endcase
        end
    end

    // Drop to unknown when any reserved bit is set
    assign o_code = ((i_word & zero_mask) != MSK_NONE) ? MN_UNKNOWN : code_raw;

endmodule : iwd_classify

`default_nettype wire

### rtl/core/instruction_word_decoder.sv
// ----------------------------------------------------------------------------
// instruction_word_decoder
// MIPS32 instruction word classifier with stream input and output.
// ----------------------------------------------------------------------------
// Each 32-bit word taken on the input stream yields exactly one result
// transfer: a 6-bit mnemonic code (0 when the opcode or function code is not
// recognized or a reserved field is nonzero) followed by the raw rs, rt, rd,
// shamt, immediate and jump-target slices of the word. The block is a
// two-register pipe: an input register holds the accepted word, and one pass
// of decode logic fills the result register. Throughput is one word per
// cycle while the output does not stall. An accepted word moves from the
// input register through the decode logic into the result register, and
// leaves from there. Ready propagates from the output side back to the
// input, so a stall on the output holds the result stage, and the input
// stage once it is full; a full pipe accepts a new word in the same cycle
// the waiting result is taken. Reset clears only the valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module instruction_word_decoder
    import iwd_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    // Input stream: tdata = instr_word[31:0]
    input  wire                i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  wire  [WORD_W-1:0]  i_s_axis_tdata,
    // Result stream: tdata = mnemonic_code[5:0], src_reg[10:6], tgt_reg[15:11],
    // dst_reg[20:16], shift_amount[25:21], immediate[41:26],
    // jump_target[67:42], zero pad[71:68]
    output logic               o_m_axis_tvalid,
    input  wire                i_m_axis_tready,
    output logic [RES_W-1:0]   o_m_axis_tdata
);

    // Input stage
    logic  r_in_valid;
    logic  n_in_valid;
    t_word r_in_word;

    // Result stage
    logic               r_out_valid;
    logic               n_out_valid;
    t_code              r_out_code;
    t_word              r_out_word;

    logic  out_free;
    logic  in_accept;
    logic  stage_adv;
    t_code dec_code;

    // Result stage can take a new entry when empty or being drained
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign stage_adv       = r_in_valid && out_free;

    iwd_classify u_classify (
        .i_word (r_in_word),
        .o_code (dec_code)
    );

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (o_s_axis_tready) begin
            n_in_valid = i_s_axis_tvalid;
        end
        if (out_free) begin
            n_out_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload: load on transfer, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_word <= i_s_axis_tdata;
        end
        if (stage_adv) begin
            r_out_code <= dec_code;
            r_out_word <= r_in_word;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {
        {(RES_W - RES_BITS){1'b0}},
        r_out_word[TGT_W-1:0],     // jump_target
        r_out_word[IMM_W-1:0],     // immediate
        r_out_word[10:6],          // shift_amount
        r_out_word[15:11],         // dst_reg
        r_out_word[20:16],         // tgt_reg
        r_out_word[25:21],         // src_reg
        r_out_code                 // mnemonic_code
    };

`ifndef NO_ASSERTIONS
    // A decoded word always lands in the result stage on the next edge
    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage_adv |=> r_out_valid)
        else $error("advanced item did not reach result stage");

    // Input side only stalls while both stages are occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_in_valid && r_out_valid && !i_m_axis_tready))
        else $error("input stalled with room in pipe");

    // syscall reports only with bits 25..6 clear
    a_syscall_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_code == MN_SYSCALL) |-> (r_out_word[25:6] == '0))
        else $error("syscall with reserved bits set");

    // lui reports only with rs clear
    a_lui_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_code == MN_LUI) |-> (r_out_word[25:21] == '0))
        else $error("lui with nonzero rs");
`endif

endmodule : instruction_word_decoder

`default_nettype wire
